// ===== design/motor_pulse_table_interpolator_unit_assert.svh =====
// assertion macros used by the checker file
// no dependencies; include guard keeps a second include harmless
`ifndef MOTOR_PULSE_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH
`define MOTOR_PULSE_TABLE_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MPTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mpti assertion failed");

// next-cycle implication, disabled while reset is low
`define MPTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mpti assertion failed");

`endif

// ===== design/mpti_pkg.sv =====
// types and fixed constants of the pulse table interpolator
// no dependencies; used by the divider, register file, top level, checker and bench
package mpti_pkg;

	// item codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DEMAND = 1'b1;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_REV = 1'b1;

	localparam logic MODE_TIME = 1'b0;
	localparam logic MODE_POS  = 1'b1;

	// register indexes on paddr[3:2]
	localparam logic [1:0] REG_ENTRIES   = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_GAIN      = 2'd2;

	localparam int PADDR_W = 4;

	localparam logic [7:0]  ENTRIES_RST   = 8'd100;
	localparam logic [15:0] THRESHOLD_RST = 16'd100;
	localparam logic [15:0] GAIN_RST      = 16'd16384;

	localparam int GAIN_FRAC = 14;

	// arithmetic widths
	localparam int DIFF_W    = 17; // signed difference of two 16 bit values
	localparam int PROD_W    = 33; // signed product of two differences
	localparam int DIV_MAG_W = 32; // magnitude of the dividend
	localparam int DIV_CNT_W = 6;
	localparam int SCALED_W  = 18; // (16 x 16) >> 14
	localparam int SW_WIDE_W = 20;

	localparam logic signed [SW_WIDE_W-1:0] SW_MIN = -20'sd65536;
	localparam logic signed [SW_WIDE_W-1:0] SW_MAX = 20'sd131071;

	typedef struct packed {
		logic [7:0]  entries_in_use;
		logic [15:0] time_mode_threshold;
		logic [15:0] position_gain;
	} cfg_t;

	typedef struct packed {
		logic [15:0] on_time;
		logic [15:0] on_position;
		logic [15:0] settle_distance;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                     start;
		logic signed [PROD_W-1:0] dividend;
		logic signed [DIFF_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIVS,
		ST_DIVW,
		ST_SCALE,
		ST_OUT
	} state_t;

endpackage

// ===== design/mpti_if.sv =====
// valid/ready channel interfaces for request and result words
// no dependencies
interface mpti_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [6:0]  entry_index;
	logic [15:0] entry_on_time;
	logic [15:0] entry_on_position;
	logic [15:0] entry_settle_distance;
	logic [15:0] demand;
	logic [15:0] encoder_position;

	modport source (
		output valid, op, entry_index, entry_on_time, entry_on_position,
			entry_settle_distance, demand, encoder_position,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_on_time, entry_on_position,
			entry_settle_distance, demand, encoder_position,
		output ready
	);
endinterface

interface mpti_out_if;
	logic               valid;
	logic               ready;
	logic               direction;
	logic               control_mode;
	logic [15:0]        distance;
	logic [15:0]        pulse_time;
	logic signed [17:0] switch_off_position;
	logic [6:0]         segment_index;
	logic               flat_segment;

	modport source (
		output valid, direction, control_mode, distance, pulse_time,
			switch_off_position, segment_index, flat_segment,
		input  ready
	);
	modport sink (
		input  valid, direction, control_mode, distance, pulse_time,
			switch_off_position, segment_index, flat_segment,
		output ready
	);
endinterface

// ===== design/mpti_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mpti_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/mpti_div.sv =====
// signed truncating divider, one quotient bit per cycle
// depends on mpti_pkg
module mpti_div import mpti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_MAG_W-1:0] quo_q;
	logic [15:0]          rem_q;
	logic [15:0]          den_q;
	logic                 neg_q;

	logic [PROD_W-1:0]    num_abs;
	logic [DIFF_W-1:0]    den_abs;
	logic [16:0]          shifted;
	logic [16:0]          trial;
	logic                 ge;

	assign num_abs = req.dividend[PROD_W-1] ? PROD_W'(-req.dividend) : req.dividend;
	assign den_abs = req.divisor[DIFF_W-1] ? DIFF_W'(-req.divisor) : req.divisor;
	assign shifted = {rem_q, quo_q[DIV_MAG_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= num_abs[DIV_MAG_W-1:0];
			rem_q <= '0;
			den_q <= den_abs[15:0];
			neg_q <= req.dividend[PROD_W-1] ^ req.divisor[DIFF_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? trial[15:0] : shifted[15:0];
			quo_q <= {quo_q[DIV_MAG_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

// ===== design/mpti_cfg.sv =====
// apb register file: entry count, time mode threshold, position gain
// depends on mpti_pkg
module mpti_cfg import mpti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);
	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entries_in_use      <= ENTRIES_RST;
			cfg_q.time_mode_threshold <= THRESHOLD_RST;
			cfg_q.position_gain       <= GAIN_RST;
		end else if (wr_en) begin
			case (paddr[PADDR_W-1:2])
				REG_ENTRIES:   cfg_q.entries_in_use      <= pwdata[7:0];
				REG_THRESHOLD: cfg_q.time_mode_threshold <= pwdata[15:0];
				REG_GAIN:      cfg_q.position_gain       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[PADDR_W-1:2])
			REG_ENTRIES:   prdata = {24'd0, cfg_q.entries_in_use};
			REG_THRESHOLD: prdata = {16'd0, cfg_q.time_mode_threshold};
			REG_GAIN:      prdata = {16'd0, cfg_q.position_gain};
			default:       prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

// ===== design/motor_pulse_table_interpolator_unit.sv =====
// motor pulse table interpolator, top level
// depends on mpti_pkg, mpti_if, mpti_ram, mpti_div, mpti_cfg
//
// usage
//   req carries load words (op 0) that write one calibration entry and
//   demand words (op 1). rsp carries one result word per demand that
//   differs from the previous demand; loads and repeated demands give none.
//   the apb port sets entry count, time mode threshold and Q2.14 gain; the user
//   must write it only while the block is idle; the block does not enforce it.
// sequence
//   a load writes its entry when taken. a demand walks the table one entry per
//   cycle (one ram read port), then runs two multiply and divide passes, on
//   time first and on position second, then scale and output; a flat segment
//   goes from the search straight to scale and output. one word is in work at
//   a time.
// reset
//   control state, last demand and registers return to their defaults; the
//   table ram is not cleared and must be loaded before demands are sent.
// stall
//   a finished result sits in the output register; while rsp stalls the block
//   still takes words, and a later result waits in its last step until it frees
module motor_pulse_table_interpolator_unit import mpti_pkg::*; #(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	mpti_in_if.sink            req,
	mpti_out_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	cfg_t     cfg;
	state_t   state_q, state_d;

	// handshake and control strobes
	logic     in_fire;
	logic     issue;
	logic     out_load;
	logic     div_start;

	// table ram
	logic     ram_we;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t   wr_entry;
	entry_t   rd_entry;

	// search
	logic [AW-1:0] a_q;
	logic          iss_done_q;
	logic          rd_v_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          hit0_q;
	logic [AW-1:0] nlast_q;
	logic [AW-1:0] nlast_d;
	entry_t        prev_q;
	logic          hit;
	logic          stop;

	// demand context
	logic [15:0]   last_q;
	logic [15:0]   enc_q;
	logic [15:0]   dist_q;
	logic          dir_q;
	logic          mode_q;
	logic          dir_d;
	logic [15:0]   dist_d;

	// segment
	logic [AW-1:0] seg_q;
	entry_t        lo_q, hi_q;
	logic signed [DIFF_W-1:0] dd_d, ds_d, dd_q, ds_q;
	logic          flat_q;

	// interpolation
	logic                     sel_q;     // 0 on time, 1 on position
	logic signed [DIFF_W-1:0] mul_a;
	logic signed [2*DIFF_W-1:0] mul_full;
	logic signed [PROD_W-1:0] prod_q;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;
	logic [15:0]              lo_val;
	logic signed [PROD_W+1:0] v_sum;
	logic [15:0]              v_sat;
	logic [15:0]              t_q, p_q;

	// switch-off position
	logic [31:0]                 gain_prod;
	logic [SCALED_W-1:0]         scaled_q;
	logic signed [SW_WIDE_W-1:0] sw_wide;
	logic [17:0]                 sw_sat;

	// result register
	logic        rsp_valid_q;
	logic        rsp_dir_q;
	logic        rsp_mode_q;
	logic [15:0] rsp_dist_q;
	logic [15:0] rsp_time_q;
	logic [17:0] rsp_sw_q;
	logic [6:0]  rsp_seg_q;
	logic        rsp_flat_q;

	mpti_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------------------------------------------------------
	// table ram: one word per entry, written by loads, read by the search
	// ---------------------------------------------------------------
	assign wr_entry.on_time         = req.entry_on_time;
	assign wr_entry.on_position     = req.entry_on_position;
	assign wr_entry.settle_distance = req.entry_settle_distance;

	// loads past the table end are dropped
	assign ram_we = in_fire && (req.op == OP_LOAD) && (32'(req.entry_index) < TABLE_DEPTH);

	mpti_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req.entry_index)),
		.wdata (wr_entry),
		.re    (issue),
		.raddr (a_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// ---------------------------------------------------------------
	// demand front end: direction, distance, clamped entry count
	// ---------------------------------------------------------------
	assign dir_d  = (req.demand < req.encoder_position) ? DIR_REV : DIR_FWD;
	assign dist_d = (dir_d == DIR_REV) ? (req.encoder_position - req.demand)
	                                   : (req.demand - req.encoder_position);

	always_comb begin
		if (cfg.entries_in_use < 8'd2) begin
			nlast_d = AW'(1);
		end else if (32'(cfg.entries_in_use) > TABLE_DEPTH) begin
			nlast_d = LAST_IDX;
		end else begin
			nlast_d = AW'(32'(cfg.entries_in_use) - 32'd1);
		end
	end

	// ---------------------------------------------------------------
	// search: reads stream one per cycle, each compared in the cycle after its read.
	// a hit on entry 0 still uses segment (0, 1), so the walk goes on one
	// more entry; running off the end settles on the last segment
	// ---------------------------------------------------------------
	assign hit  = (rd_entry.settle_distance > dist_q);
	assign stop = (state_q == ST_SEARCH) && rd_v_s1 && (rd_idx_s1 != '0)
	              && (hit || hit0_q || (rd_idx_s1 == nlast_q));

	assign dd_d = $signed({1'b0, dist_q}) - $signed({1'b0, prev_q.settle_distance});
	assign ds_d = $signed({1'b0, rd_entry.settle_distance})
	              - $signed({1'b0, prev_q.settle_distance});

	// ---------------------------------------------------------------
	// interpolation: shared multiplier, then the shared divider
	// ---------------------------------------------------------------
	always_comb begin
		if (sel_q) begin
			mul_a  = $signed({1'b0, hi_q.on_position}) - $signed({1'b0, lo_q.on_position});
			lo_val = lo_q.on_position;
		end else begin
			mul_a  = $signed({1'b0, hi_q.on_time}) - $signed({1'b0, lo_q.on_time});
			lo_val = lo_q.on_time;
		end
	end

	assign mul_full = mul_a * dd_q;

	assign div_req.start    = div_start;
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = ds_q;

	mpti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// lower value plus truncated quotient, saturated to 16 bits
	assign v_sum = $signed({19'd0, lo_val}) + (PROD_W+2)'(div_rsp.quotient);

	always_comb begin
		if (v_sum < 0) begin
			v_sat = 16'd0;
		end else if (v_sum > $signed((PROD_W+2)'(65535))) begin
			v_sat = 16'hFFFF;
		end else begin
			v_sat = v_sum[15:0];
		end
	end

	// ---------------------------------------------------------------
	// switch-off position: encoder +/- (p * gain) >> 14, saturated
	// ---------------------------------------------------------------
	assign gain_prod = p_q * cfg.position_gain;

	always_comb begin
		if (dir_q == DIR_REV) begin
			sw_wide = $signed({4'd0, enc_q}) - $signed({2'd0, scaled_q});
		end else begin
			sw_wide = $signed({4'd0, enc_q}) + $signed({2'd0, scaled_q});
		end
		if (sw_wide < SW_MIN) begin
			sw_sat = SW_MIN[17:0];
		end else if (sw_wide > SW_MAX) begin
			sw_sat = SW_MAX[17:0];
		end else begin
			sw_sat = sw_wide[17:0];
		end
	end

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (req.op == OP_DEMAND) && (req.demand != last_q)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (stop) begin
					state_d = (ds_d == '0) ? ST_SCALE : ST_MUL;
				end
			end
			ST_MUL:   state_d = ST_DIVS;
			ST_DIVS:  state_d = ST_DIVW;
			ST_DIVW: begin
				if (div_rsp.done) begin
					state_d = sel_q ? ST_SCALE : ST_MUL;
				end
			end
			ST_SCALE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_SEARCH: issue     = !iss_done_q && !stop;
			ST_DIVS:   div_start = 1'b1;
			ST_OUT:    out_load  = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign in_fire = req.valid && req.ready;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= '0;
			a_q         <= '0;
			iss_done_q  <= 1'b0;
			rd_v_s1     <= 1'b0;
			hit0_q      <= 1'b0;
			sel_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;

			if (in_fire && (req.op == OP_DEMAND) && (req.demand != last_q)) begin
				last_q     <= req.demand;
				a_q        <= '0;
				iss_done_q <= 1'b0;
				hit0_q     <= 1'b0;
				sel_q      <= 1'b0;
			end

			if (issue) begin
				if (a_q == nlast_q) begin
					iss_done_q <= 1'b1;
				end else begin
					a_q <= a_q + 1'b1;
				end
			end

			if ((state_q == ST_SEARCH) && rd_v_s1 && (rd_idx_s1 == '0) && hit) begin
				hit0_q <= 1'b1;
			end

			if ((state_q == ST_DIVW) && div_rsp.done) begin
				sel_q <= 1'b1;
			end

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= a_q;

		if (in_fire && (req.op == OP_DEMAND)) begin
			enc_q   <= req.encoder_position;
			dir_q   <= dir_d;
			dist_q  <= dist_d;
			mode_q  <= (dist_d <= cfg.time_mode_threshold) ? MODE_TIME : MODE_POS;
			nlast_q <= nlast_d;
		end

		if (rd_v_s1) begin
			prev_q <= rd_entry;
		end

		if (stop) begin
			seg_q  <= rd_idx_s1;
			lo_q   <= prev_q;
			hi_q   <= rd_entry;
			dd_q   <= dd_d;
			ds_q   <= ds_d;
			flat_q <= (ds_d == '0);
			// flat segment takes the lower entry as is
			t_q    <= prev_q.on_time;
			p_q    <= prev_q.on_position;
		end

		if (state_q == ST_MUL) begin
			prod_q <= mul_full[PROD_W-1:0];
		end

		if ((state_q == ST_DIVW) && div_rsp.done) begin
			if (sel_q) begin
				p_q <= v_sat;
			end else begin
				t_q <= v_sat;
			end
		end

		if (state_q == ST_SCALE) begin
			scaled_q <= gain_prod[31:GAIN_FRAC];
		end

		if (out_load) begin
			rsp_dir_q  <= dir_q;
			rsp_mode_q <= mode_q;
			rsp_dist_q <= dist_q;
			rsp_time_q <= t_q;
			rsp_sw_q   <= sw_sat;
			rsp_seg_q  <= 7'(seg_q);
			rsp_flat_q <= flat_q;
		end
	end

	assign rsp.valid               = rsp_valid_q;
	assign rsp.direction           = rsp_dir_q;
	assign rsp.control_mode        = rsp_mode_q;
	assign rsp.distance            = rsp_dist_q;
	assign rsp.pulse_time          = rsp_time_q;
	assign rsp.switch_off_position = $signed(rsp_sw_q);
	assign rsp.segment_index       = rsp_seg_q;
	assign rsp.flat_segment        = rsp_flat_q;
endmodule

// ===== design/mpti_checker.sv =====
// port-level checker for the pulse table interpolator, bound to the top
// depends on mpti_pkg and the assertion macro header
`include "motor_pulse_table_interpolator_unit_assert.svh"

module mpti_checker import mpti_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_direction,
	input logic               rsp_control_mode,
	input logic [15:0]        rsp_distance,
	input logic signed [17:0] rsp_switch_off_position
);
	// a stalled result word stays up
	`MPTI_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	// a new result word is only loaded while the input side is closed
	`MPTI_ASSERT_NOW(a_rsp_rise, clk, arst_n, $rose(rsp_valid), !$past(req_ready))

	// zero distance is always within the threshold
	`MPTI_ASSERT_NOW(a_zero_dist, clk, arst_n, rsp_valid && (rsp_distance == 16'd0),
		rsp_control_mode == MODE_TIME)

	// forward moves never switch off below zero, reverse ones never above the encoder range
	`MPTI_ASSERT_NOW(a_sw_dir, clk, arst_n, rsp_valid,
		(rsp_direction == DIR_FWD) ? (rsp_switch_off_position >= 0)
		                           : (rsp_switch_off_position <= 18'sd65535))
endmodule

bind motor_pulse_table_interpolator_unit mpti_checker u_mpti_checker (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.req_ready               (req.ready),
	.rsp_valid               (rsp.valid),
	.rsp_ready               (rsp.ready),
	.rsp_direction           (rsp.direction),
	.rsp_control_mode        (rsp.control_mode),
	.rsp_distance            (rsp.distance),
	.rsp_switch_off_position (rsp.switch_off_position)
);

// ===== dv/motor_pulse_table_interpolator_unit_tb.sv =====
// self-checking bench for the pulse table interpolator: table loads, demands and
// apb register settings, checked word by word against an in-bench interpolator or typed rows
// depends on mpti_pkg, mpti_if and the design files
module motor_pulse_table_interpolator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mpti_pkg::*;

	localparam int DEPTH           = 128;
	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int DRAIN_CYCLES    = 300;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int DEMO_ROWS       = 19;

	typedef struct packed {
		logic        op;
		logic [6:0]  entry_index;
		logic [15:0] entry_on_time;
		logic [15:0] entry_on_position;
		logic [15:0] entry_settle_distance;
		logic [15:0] demand;
		logic [15:0] encoder_position;
	} req_word_t;

	typedef struct packed {
		logic               direction;
		logic               control_mode;
		logic [15:0]        distance;
		logic [15:0]        pulse_time;
		logic signed [17:0] switch_off_position;
		logic [6:0]         segment_index;
		logic               flat_segment;
	} pulse_word_t;

	// how a stimulus row is checked: by the interpolator, as no result, or as typed
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} check_kind_t;

	typedef struct packed {
		check_kind_t kind;
		req_word_t   w;
		pulse_word_t want;
	} demo_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;

	mpti_in_if  req_if();
	mpti_out_if rsp_if();

	motor_pulse_table_interpolator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the calibration table, last demand and registers
	logic [15:0] cal_on_time [DEPTH];
	logic [15:0] cal_on_pos [DEPTH];
	logic [15:0] cal_settle [DEPTH];
	logic [15:0] prev_demand;
	cfg_t        cfg;

	pulse_word_t pending_pulses [$];

	int fault_count = 0;
	int cycle_count = 0;
	int sender_calm = 0;
	int taker_calm  = 0;

	// register plan per random phase; phases 4 to 6 are redrawn at run time
	logic [7:0]  entry_plan [PHASES] = '{8'd128, 8'd2, 8'd255, 8'd1, 8'd64, 8'd0, 8'd0, 8'd100};
	logic [15:0] thr_plan [PHASES]   = '{16'd0, 16'd65535, 16'd1000, 16'd300,
		16'd0, 16'd0, 16'd0, 16'd100};
	logic [15:0] gain_plan [PHASES]  = '{16'd65535, 16'd0, 16'd16384, 16'd8192,
		16'd0, 16'd0, 16'd0, 16'd16384};

	// directed rows, run with a two entry search, threshold 100 and unity gain
	demo_row_t demo_rows [DEMO_ROWS] = '{
		// two entry table: (t 100, p 1000, s 10) and (t 1100, p 3000, s 110)
		'{CHK_MODEL, '{OP_LOAD, 7'd0, 16'd100, 16'd1000, 16'd10, 16'd0, 16'd0}, '0},
		'{CHK_MODEL, '{OP_LOAD, 7'd1, 16'd1100, 16'd3000, 16'd110, 16'd0, 16'd0}, '0},
		// demand equal to the reset value of the last demand gives nothing
		'{CHK_NONE, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1234}, '0},
		// mid segment, halfway between the two entries
		'{CHK_TYPED, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd60, 16'd0},
			'{DIR_FWD, MODE_TIME, 16'd60, 16'd600, 18'sd2000, 7'd1, 1'b0}},
		// repeated demand with another encoder count still gives nothing
		'{CHK_NONE, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd60, 16'd5}, '0},
		// full scale forward and reverse: past the table end, both saturate
		'{CHK_TYPED, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd0},
			'{DIR_FWD, MODE_POS, 16'd65535, 16'd65535, 18'sd65535, 7'd1, 1'b0}},
		'{CHK_TYPED, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535},
			'{DIR_REV, MODE_POS, 16'd65535, 16'd65535, 18'sd0, 7'd1, 1'b0}},
		// below the first entry, extrapolated with a negative quotient
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd105, 16'd100}, '0},
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd93, 16'd100}, '0},
		// distance on the threshold and one above
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd300, 16'd200}, '0},
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd301, 16'd200}, '0},
		// flat segment takes the lower entry
		'{CHK_MODEL, '{OP_LOAD, 7'd1, 16'd7, 16'd8, 16'd10, 16'd0, 16'd0}, '0},
		'{CHK_TYPED, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd500, 16'd200},
			'{DIR_FWD, MODE_POS, 16'd300, 16'd100, 18'sd1200, 7'd1, 1'b1}},
		// descending settling distances, zero distance
		'{CHK_MODEL, '{OP_LOAD, 7'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, '0},
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd4, 16'd4}, '0},
		// extrapolation below zero saturates time and position at zero
		'{CHK_MODEL, '{OP_LOAD, 7'd0, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0}, '0},
		'{CHK_MODEL, '{OP_LOAD, 7'd1, 16'd1000, 16'd65535, 16'd200, 16'd0, 16'd0}, '0},
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd30000, 16'd30000}, '0},
		'{CHK_MODEL, '{OP_DEMAND, 7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, '0}
	};

	// wait per word: random, with runs of back-to-back words now and then
	function automatic int pick_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(15) == 0) begin
			calm_left = int'($urandom_range(40, 10));
			return 0;
		end
		return int'($urandom_range(19));
	endfunction

	function automatic logic [31:0] reg_mask(input logic [1:0] idx);
		return (idx == REG_ENTRIES) ? 32'h0000_00FF : 32'h0000_FFFF;
	endfunction

	function automatic void check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			fault_count++;
		end
	endfunction

	// applies one request word to the bench state; returns 1 with the pulse
	// word when the request produces one
	function automatic bit interpolate_demand(input req_word_t w, output pulse_word_t r);
		int unsigned travel, n, seg;
		longint s_lo, s_hi, t_lo, t_hi, p_lo, p_hi, t, p, dd, ds, gain_l, enc_l, scaled, sw;
		bit rev, flat;
		r = '0;
		flat = 1'b0;
		if (w.op == OP_LOAD) begin
			cal_on_time[w.entry_index] = w.entry_on_time;
			cal_on_pos[w.entry_index]  = w.entry_on_position;
			cal_settle[w.entry_index]  = w.entry_settle_distance;
			return 1'b0;
		end
		if (w.demand == prev_demand)
			return 1'b0;
		prev_demand = w.demand;

		rev    = (w.demand < w.encoder_position);
		travel = rev ? 32'(w.encoder_position) - 32'(w.demand)
			: 32'(w.demand) - 32'(w.encoder_position);

		// entry count is clamped to the table, the search stops at the first
		// settling distance above the travel, and the segment never starts below 0
		n = 32'(cfg.entries_in_use);
		if (n < 2) n = 2;
		if (n > DEPTH) n = DEPTH;
		seg = n - 1;
		for (int i = 0; i < int'(n); i++) begin
			if (32'(cal_settle[i]) > travel) begin
				seg = 32'(i);
				break;
			end
		end
		if (seg == 0) seg = 1;

		s_lo = cal_settle[seg-1];
		s_hi = cal_settle[seg];
		t_lo = cal_on_time[seg-1];
		t_hi = cal_on_time[seg];
		p_lo = cal_on_pos[seg-1];
		p_hi = cal_on_pos[seg];
		if (s_lo == s_hi) begin
			flat = 1'b1;
			t = t_lo;
			p = p_lo;
		end else begin
			// signed interpolation, division truncates toward zero
			dd = longint'(travel) - s_lo;
			ds = s_hi - s_lo;
			t  = t_lo + ((t_hi - t_lo) * dd) / ds;
			p  = p_lo + ((p_hi - p_lo) * dd) / ds;
		end
		if (t < 0) t = 0;
		if (t > 65535) t = 65535;
		if (p < 0) p = 0;
		if (p > 65535) p = 65535;

		gain_l = cfg.position_gain;
		enc_l  = w.encoder_position;
		scaled = (p * gain_l) >> GAIN_FRAC;
		sw     = rev ? enc_l - scaled : enc_l + scaled;
		if (sw < -65536) sw = -65536;
		if (sw > 131071) sw = 131071;

		r.direction           = rev ? DIR_REV : DIR_FWD;
		r.control_mode        = (travel <= 32'(cfg.time_mode_threshold)) ? MODE_TIME : MODE_POS;
		r.distance            = travel[15:0];
		r.pulse_time          = t[15:0];
		r.switch_off_position = sw[17:0];
		r.segment_index       = seg[6:0];
		r.flat_segment        = flat;
		return 1'b1;
	endfunction

	// drives one request word from the falling edge and holds it until taken
	task automatic send_request(input req_word_t w, input check_kind_t kind,
		input pulse_word_t typed);
		pulse_word_t r;
		bit has;
		int gap;
		gap = pick_wait(sender_calm);
		@(negedge clk);
		if (gap != 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.op                    = w.op;
		req_if.entry_index           = w.entry_index;
		req_if.entry_on_time         = w.entry_on_time;
		req_if.entry_on_position     = w.entry_on_position;
		req_if.entry_settle_distance = w.entry_settle_distance;
		req_if.demand                = w.demand;
		req_if.encoder_position      = w.encoder_position;
		req_if.valid                 = 1'b1;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		// the bench state moves on every accepted word, typed rows included
		has = interpolate_demand(w, r);
		case (kind)
			CHK_MODEL: begin
				if (has) pending_pulses.push_back(r);
			end
			CHK_TYPED: begin
				pending_pulses.push_back(typed);
			end
			default: begin
			end
		endcase
	endtask

	// sender goes quiet until every pulse word is back, then lets any
	// resultless demand still in flight finish
	task automatic wait_idle();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic verify_register(input logic [1:0] idx, input logic [31:0] want);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		check_field($sformatf("register %0d readback", idx), 64'(want & reg_mask(idx)),
			64'(prdata & reg_mask(idx)));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// apb write with junk above the register width, then read back
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = ($urandom & ~reg_mask(idx)) | (value & reg_mask(idx));
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (idx)
			REG_ENTRIES:   cfg.entries_in_use = value[7:0];
			REG_THRESHOLD: cfg.time_mode_threshold = value[15:0];
			default:       cfg.position_gain = value[15:0];
		endcase
		verify_register(idx, value);
	endtask

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls, each accepted word checked against the oldest
	initial begin
		pulse_word_t want;
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_wait(taker_calm);
			@(negedge clk);
			if (stall != 0) begin
				rsp_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
			if (pending_pulses.size() == 0) begin
				$display("%0t: result word with nothing pending, distance %0d pulse %0d",
					$time, rsp_if.distance, rsp_if.pulse_time);
				fault_count++;
			end else begin
				want = pending_pulses.pop_front();
				check_field("direction", 64'(want.direction), 64'(rsp_if.direction));
				check_field("control_mode", 64'(want.control_mode), 64'(rsp_if.control_mode));
				check_field("distance", 64'(want.distance), 64'(rsp_if.distance));
				check_field("pulse_time", 64'(want.pulse_time), 64'(rsp_if.pulse_time));
				check_field("switch_off_position", 64'(want.switch_off_position),
					64'(rsp_if.switch_off_position));
				check_field("segment_index", 64'(want.segment_index),
					64'(rsp_if.segment_index));
				check_field("flat_segment", 64'(want.flat_segment), 64'(rsp_if.flat_segment));
			end
		end
	end

	// stimulus
	initial begin
		req_word_t w;
		logic [7:0] ent;
		logic [15:0] thr, gain, lo, hi;
		int lim, fill_cnt, step_max, idx, span, enc_i;
		int unsigned s_acc;

		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		req_if.valid                 = 1'b0;
		req_if.op                    = OP_LOAD;
		req_if.entry_index           = '0;
		req_if.entry_on_time         = '0;
		req_if.entry_on_position     = '0;
		req_if.entry_settle_distance = '0;
		req_if.demand                = '0;
		req_if.encoder_position      = '0;
		cfg         = '{ENTRIES_RST, THRESHOLD_RST, GAIN_RST};
		prev_demand = '0;
		for (int i = 0; i < DEPTH; i++) begin
			cal_on_time[i] = '0;
			cal_on_pos[i]  = '0;
			cal_settle[i]  = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers come out of reset at their defaults
		verify_register(REG_ENTRIES, 32'(ENTRIES_RST));
		verify_register(REG_THRESHOLD, 32'(THRESHOLD_RST));
		verify_register(REG_GAIN, 32'(GAIN_RST));

		// directed part: an entry count of zero clamps the search to two entries
		write_register(REG_ENTRIES, 32'd0);
		write_register(REG_THRESHOLD, 32'd100);
		write_register(REG_GAIN, 32'd16384);
		for (int k = 0; k < DEMO_ROWS; k++)
			send_request(demo_rows[k].w, demo_rows[k].kind, demo_rows[k].want);

		// random phases, each behind an idle point with its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			ent  = entry_plan[ph];
			thr  = thr_plan[ph];
			gain = gain_plan[ph];
			if (ph >= 4 && ph <= 6) begin
				ent  = (ph == 6) ? 8'($urandom_range(128, 2)) : 8'($urandom);
				thr  = 16'($urandom);
				gain = 16'($urandom);
			end
			wait_idle();
			write_register(REG_ENTRIES, 32'(ent));
			write_register(REG_THRESHOLD, 32'(thr));
			write_register(REG_GAIN, 32'(gain));

			lim = int'(cfg.entries_in_use);
			if (lim < 2) lim = 2;
			if (lim > DEPTH) lim = DEPTH;

			// fresh ascending table over the searched entries; the first phase
			// fills the whole table so no unwritten entry is ever read
			fill_cnt = (ph == 0) ? DEPTH : lim;
			case ($urandom_range(2))
				0:       step_max = 8;
				1:       step_max = 65535 / fill_cnt;
				default: step_max = 2000;
			endcase
			s_acc = $urandom_range(200);
			for (int i = 0; i < fill_cnt; i++) begin
				w.op                    = OP_LOAD;
				w.entry_index           = 7'(i);
				w.entry_on_time         = 16'($urandom);
				w.entry_on_position     = 16'($urandom);
				w.entry_settle_distance = 16'(s_acc);
				w.demand                = 16'($urandom);
				w.encoder_position      = 16'($urandom);
				send_request(w, CHK_MODEL, '0);
				// an occasional zero step leaves a flat segment
				if ($urandom_range(9) != 0)
					s_acc = s_acc + $urandom_range(32'(step_max), 1);
				if (s_acc > 65535) s_acc = 65535;
			end

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				w.entry_index           = 7'($urandom);
				w.entry_on_time         = 16'($urandom);
				w.entry_on_position     = 16'($urandom);
				w.entry_settle_distance = 16'($urandom);
				w.demand                = 16'($urandom);
				w.encoder_position      = 16'($urandom);
				if ($urandom_range(99) < 25) begin
					// rewrite one entry: mostly keeping order, sometimes flat or wild
					w.op = OP_LOAD;
					idx  = int'(w.entry_index);
					lo   = (idx == 0) ? 16'd0 : cal_settle[idx-1];
					hi   = (idx == DEPTH - 1) ? 16'hFFFF : cal_settle[idx+1];
					case ($urandom_range(3))
						0, 1: begin
							if (lo <= hi)
								w.entry_settle_distance = 16'($urandom_range(32'(hi), 32'(lo)));
						end
						2: w.entry_settle_distance = lo;
						default: begin
						end
					endcase
				end else begin
					w.op = OP_DEMAND;
					if ($urandom_range(19) == 0) begin
						w.demand = prev_demand;
					end else begin
						// aim the travel at a table entry, at the threshold, or anywhere
						case ($urandom_range(2))
							0: span = int'(cal_settle[$urandom_range(32'(lim - 1))])
								+ int'($urandom_range(4)) - 2;
							1: span = int'(cfg.time_mode_threshold) + int'($urandom_range(2)) - 1;
							default: span = int'($urandom_range(65535));
						endcase
						if (span < 0) span = 0;
						enc_i = int'(w.encoder_position);
						if ($urandom_range(1) == 0 && enc_i + span <= 65535)
							w.demand = 16'(enc_i + span);
						else if (enc_i - span >= 0)
							w.demand = 16'(enc_i - span);
						else if (enc_i + span <= 65535)
							w.demand = 16'(enc_i + span);
					end
				end
				send_request(w, CHK_MODEL, '0);
			end
		end

		wait_idle();
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== motor_pulse_table_interpolator_unit.f =====
+incdir+design
design/mpti_pkg.sv
design/mpti_if.sv
design/mpti_ram.sv
design/mpti_div.sv
design/mpti_cfg.sv
design/motor_pulse_table_interpolator_unit.sv
design/mpti_checker.sv
dv/motor_pulse_table_interpolator_unit_tb.sv
